### hw/rtl/fqd_pkg.sv
// Shared types and constants for the FIFO queue with delete-by-value.
package fqd_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int HANDLE_W_DEF = 32;
  localparam int OCC_W        = 6;
  localparam int ACTION_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  // Read address select for the single memory read port.
  typedef enum logic [1:0] {
    RD_HEAD    = 2'd0,
    RD_SP      = 2'd1,
    RD_SP_NEXT = 2'd2
  } rd_sel_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    accept;     // transfer taken: latch handle, reset scan pointer
    logic    enq;        // write handle at tail, count + 1
    logic    rd_en;      // issue memory read
    rd_sel_t rd_sel;
    logic    deq_fin;    // pop head, count - 1
    logic    srch_next;  // advance scan pointer
    logic    mv_wr;      // copy read data down one slot, advance scan pointer
    logic    del_fin;    // count - 1 after gap closed
    logic    fin;        // load result registers
    logic    fin_fail;
    logic    fin_deq;    // result carries the read data
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic in_null;  // handle on the input port is zero
    logic full;
    logic empty;
    logic match;    // read data equals the latched handle
    logic last;     // scan index is the youngest entry
  } sts_t;

endpackage

### hw/rtl/fifo_queue_with_delete_unit.sv
// Top level of the FIFO queue with delete-by-value.
//
// A bounded FIFO of nonzero handles kept in arrival order. A command transfer
// happens at a rising edge with start high and busy low; exactly one result
// follows, shown on status/handle_out/occupancy for one cycle with done high.
// The receiver cannot stall, so capture the result on the done cycle. Entries
// live in a single-port-read circular memory (one read, one write per cycle),
// so dequeue is a pointer move and no memory clear is needed after reset.
// Sequencing, per action:
//   enqueue (or any failed enqueue, unused action): done the next cycle, busy
//     stays low, so enqueues can go back to back.
//   dequeue: busy in S_DEQ while the registered head read lands, then done.
//   delete: a read/compare pair per entry scanned, then a read/write pair per
//     entry moved down to close the gap; a null handle or empty queue fails
//     at once like enqueue.
// done is always seen with busy low, and a new command may transfer during the
// done cycle. occupancy is the count after the step, truncated to 6 bits.
module fifo_queue_with_delete_unit #(
  parameter int CAPACITY     = fqd_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = fqd_pkg::HANDLE_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [fqd_pkg::ACTION_W-1:0] action,
  input  logic [HANDLE_WIDTH-1:0]   handle_in,
  output logic                      done,
  output logic                      status,
  output logic [HANDLE_WIDTH-1:0]   handle_out,
  output logic [fqd_pkg::OCC_W-1:0] occupancy
);
  import fqd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: decode, scan and gap-close loop
  fqd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // storage, pointers, count and result registers
  fqd_dp #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .handle_in  (handle_in),
    .cmd        (cmd),
    .sts        (sts),
    .status     (status),
    .handle_out (handle_out),
    .occupancy  (occupancy),
    .done       (done)
  );

  // every finishing path returns the controller to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

endmodule

### hw/rtl/fqd_ctrl.sv
// Controller state machine for the FIFO queue with delete-by-value.
module fqd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    action,
  input  fqd_pkg::sts_t sts,
  output fqd_pkg::cmd_t cmd,
  output logic          busy
);
  import fqd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEQ  = 6'b000010,
    S_SRD  = 6'b000100,
    S_SCMP = 6'b001000,
    S_MRD  = 6'b010000,
    S_MWR  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (action)
            ACT_ENQ: begin
              cmd.fin = 1'b1;
              if (!sts.in_null && !sts.full) begin
                cmd.enq = 1'b1;
              end else begin
                cmd.fin_fail = 1'b1;
              end
            end
            ACT_DEQ: begin
              if (sts.empty) begin
                cmd.fin      = 1'b1;
                cmd.fin_fail = 1'b1;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HEAD;
                state_next = S_DEQ;
              end
            end
            ACT_DEL: begin
              if (sts.in_null || sts.empty) begin
                cmd.fin      = 1'b1;
                cmd.fin_fail = 1'b1;
              end else begin
                state_next = S_SRD;
              end
            end
            default: begin
              cmd.fin      = 1'b1;
              cmd.fin_fail = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.deq_fin = 1'b1;
        cmd.fin     = 1'b1;
        cmd.fin_deq = 1'b1;
        state_next  = S_IDLE;
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SP;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          state_next = S_MRD;
        end else if (sts.last) begin
          cmd.fin      = 1'b1;
          cmd.fin_fail = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.srch_next = 1'b1;
          state_next    = S_SRD;
        end
      end
      S_MRD: begin
        if (sts.last) begin
          cmd.del_fin = 1'b1;
          cmd.fin     = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SP_NEXT;
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.mv_wr  = 1'b1;
        state_next = S_MRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/fqd_dp.sv
// Datapath for the FIFO queue with delete-by-value: circular entry memory,
// pointers, occupancy count and result registers.
module fqd_dp #(
  parameter int CAPACITY     = fqd_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = fqd_pkg::HANDLE_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [HANDLE_WIDTH-1:0]  handle_in,
  input  fqd_pkg::cmd_t            cmd,
  output fqd_pkg::sts_t            sts,
  output logic                     status,
  output logic [HANDLE_WIDTH-1:0]  handle_out,
  output logic [fqd_pkg::OCC_W-1:0] occupancy,
  output logic                     done
);
  import fqd_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [HANDLE_WIDTH-1:0] mem [CAPACITY];
  logic [HANDLE_WIDTH-1:0] rdata;
  logic [HANDLE_WIDTH-1:0] hreg;
  logic [AW-1:0]           head;
  logic [AW-1:0]           sp;
  logic [CW-1:0]           k;
  logic [CW-1:0]           count, count_next;

  logic [AW-1:0]           sp_inc, head_inc, tail, raddr, waddr;
  logic [CW:0]             tail_sum, tail_wrap;
  logic [HANDLE_WIDTH-1:0] wdata;
  logic                    we;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    if (p == AW'(CAPACITY - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign sp_inc   = inc_ptr(sp);
  assign head_inc = inc_ptr(head);

  // tail = (head + count) mod CAPACITY; the sum stays below 2 * CAPACITY
  assign tail_sum  = (CW+1)'(head) + (CW+1)'(count);
  assign tail_wrap = (tail_sum >= (CW+1)'(CAPACITY)) ?
                     tail_sum - (CW+1)'(CAPACITY) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:    raddr = head;
      RD_SP:      raddr = sp;
      RD_SP_NEXT: raddr = sp_inc;
      default:    raddr = sp;
    endcase
  end

  assign we    = cmd.enq | cmd.mv_wr;
  assign waddr = cmd.enq ? tail : sp;
  assign wdata = cmd.enq ? handle_in : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + 1'b1;
    end else if (cmd.deq_fin || cmd.del_fin) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.fin;
      if (cmd.deq_fin) begin
        head <= head_inc;
      end
    end
  end

  // scan state and results need no reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hreg <= handle_in;
      sp   <= head;
      k    <= '0;
    end else if (cmd.srch_next || cmd.mv_wr) begin
      sp <= sp_inc;
      k  <= k + 1'b1;
    end
    if (cmd.fin) begin
      status     <= cmd.fin_fail;
      handle_out <= cmd.fin_deq ? rdata : '0;
      occupancy  <= OCC_W'(count_next);
    end
  end

  assign sts.in_null = (handle_in == '0);
  assign sts.full    = (count == CW'(CAPACITY));
  assign sts.empty   = (count == '0);
  assign sts.match   = (rdata == hreg);
  assign sts.last    = ((k + CW'(1)) == count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy count above capacity");

  a_deq_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_fin |=> (count == $past(count) - CW'(1)))
    else $error("dequeue did not drop count by one");

  a_hout_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (handle_out != '0)) |-> !status)
    else $error("nonzero handle_out on a failed step");

endmodule
